// ===== rtl/vrks_pkg.sv =====
// vrks_pkg: shared constants for the vector reflection pipeline.
// No dependencies.
`timescale 1ns / 1ps

package vrks_pkg;

	// surface normal format: signed Q1.16 in 18 bits
	localparam int NORM_W    = 18;
	localparam int NORM_FRAC = 16;

	// default velocity word width (signed Q15.16)
	localparam int VEL_WIDTH_DEF = 32;

endpackage

// ===== rtl/vector_reflect_keep_speed.sv =====
// vector_reflect_keep_speed: top level of the velocity reflection pipeline.
// Uses vrks_pkg, vrks_delay, vrks_front, vrks_sqrt, vrks_div.
`timescale 1ns / 1ps

// Fully pipelined: one transfer per cycle in and out while not stalled. The
// square root takes one bit per stage over VEL_WIDTH + 10 stages, and the
// divider one quotient bit per stage over VEL_WIDTH stages. Each result
// reports the mirror or speed-keeping case and any clamping. A stall on the
// result side holds the whole pipeline, and vel_stall follows it.

module vector_reflect_keep_speed #(
	parameter int VEL_WIDTH = vrks_pkg::VEL_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               vel_valid,
	output logic                               vel_stall,
	input  logic signed [VEL_WIDTH-1:0]        vel_x,
	input  logic signed [VEL_WIDTH-1:0]        vel_y,
	input  logic signed [VEL_WIDTH-1:0]        vel_z,
	input  logic signed [vrks_pkg::NORM_W-1:0] norm_x,
	input  logic signed [vrks_pkg::NORM_W-1:0] norm_y,
	input  logic signed [vrks_pkg::NORM_W-1:0] norm_z,
	output logic                               res_valid,
	input  logic                               res_stall,
	output logic signed [VEL_WIDTH-1:0]        out_x,
	output logic signed [VEL_WIDTH-1:0]        out_y,
	output logic signed [VEL_WIDTH-1:0]        out_z,
	output logic                               inverted_branch,
	output logic                               saturated
);

	import vrks_pkg::*;

	localparam int W    = VEL_WIDTH;
	localparam int WW   = W + 9;
	localparam int SPL  = (WW + 1) / 2;
	localparam int HW   = WW - SPL;
	localparam int SQW  = 2 * WW + 2;
	localparam int RW   = SQW / 2;
	localparam int NW   = WW + W;
	localparam int SIDW = 6 + 3 * W;
	localparam int SIDE_DEPTH = RW + W + 4;
	localparam int MAG_DEPTH  = RW + 2;

	localparam logic signed [WW-1:0] VMAX_E = WW'({1'b0, {(W-1){1'b1}}});
	localparam logic signed [WW-1:0] VMIN_E = -VMAX_E - WW'(1);

	logic en;
	assign en        = !res_valid || !res_stall;
	assign vel_stall = !en;

	// ---------------- front: dot product and reflected vector
	logic signed [W-1:0]      vel_in [3];
	logic signed [NORM_W-1:0] norm_in [3];
	logic                     valid_s4, inv_s4;
	logic signed [W-1:0]      vel_s4 [3];
	logic signed [WW-1:0]     w_s4 [3];

	assign vel_in[0]  = vel_x;
	assign vel_in[1]  = vel_y;
	assign vel_in[2]  = vel_z;
	assign norm_in[0] = norm_x;
	assign norm_in[1] = norm_y;
	assign norm_in[2] = norm_z;

	vrks_front #(.W(W)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vel_valid),
		.vel_in   (vel_in),
		.norm_in  (norm_in),
		.valid_s4 (valid_s4),
		.inv_s4   (inv_s4),
		.vel_s4   (vel_s4),
		.w_s4     (w_s4)
	);

	// ---------------- mirror result, magnitudes, signs
	logic [W-1:0]  mir [3];
	logic [2:0]    mir_clip, sgn;
	logic [WW-1:0] mag [6];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mir_clip[i] = 1'b1;
			if (w_s4[i] > VMAX_E) begin
				mir[i] = VMAX_E[W-1:0];
			end else if (w_s4[i] < VMIN_E) begin
				mir[i] = VMIN_E[W-1:0];
			end else begin
				mir[i]      = w_s4[i][W-1:0];
				mir_clip[i] = 1'b0;
			end
			sgn[i]     = w_s4[i][WW-1];
			mag[i]     = sgn[i] ? WW'(-w_s4[i]) : WW'(w_s4[i]);
			mag[i + 3] = vel_s4[i][W-1] ? WW'(-(WW'(vel_s4[i]))) : WW'(vel_s4[i]);
		end
	end

	logic [SIDW-1:0] side_in, side_out;
	assign side_in = {valid_s4, inv_s4, |mir_clip, sgn, mir[2], mir[1], mir[0]};

	vrks_delay #(.DW(SIDW), .DEPTH(SIDE_DEPTH)) u_side_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (side_in),
		.dout   (side_out)
	);

	logic [3*WW-1:0] mw_out;

	vrks_delay #(.DW(3*WW), .DEPTH(MAG_DEPTH)) u_mag_dly (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    ({mag[2], mag[1], mag[0]}),
		.dout   (mw_out)
	);

	// ---------------- squares in halves, then sums
	logic [2*HW-1:0]   hh_s5 [6];
	logic [HW+SPL-1:0] hl_s5 [6];
	logic [2*SPL-1:0]  ll_s5 [6];
	logic [SQW-1:0]    sq [6];
	logic [SQW-1:0]    sqw_s6, sqv_s6;

	always_comb begin
		for (int j = 0; j < 6; j++) begin
			sq[j] = (SQW'(hh_s5[j]) << (2 * SPL)) + (SQW'(hl_s5[j]) << (SPL + 1))
				+ SQW'(ll_s5[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 6; j++) begin
				hh_s5[j] <= (2*HW)'(mag[j][WW-1:SPL]) * (2*HW)'(mag[j][WW-1:SPL]);
				hl_s5[j] <= (HW+SPL)'(mag[j][WW-1:SPL]) * (HW+SPL)'(mag[j][SPL-1:0]);
				ll_s5[j] <= (2*SPL)'(mag[j][SPL-1:0]) * (2*SPL)'(mag[j][SPL-1:0]);
			end
			sqw_s6 <= sq[0] + sq[1] + sq[2];
			sqv_s6 <= sq[3] + sq[4] + sq[5];
		end
	end

	// ---------------- speeds
	logic [RW-1:0] news, olds;

	vrks_sqrt #(.IW(SQW)) u_sqrt_new (
		.clk  (clk),
		.en   (en),
		.rad  (sqw_s6),
		.root (news)
	);

	vrks_sqrt #(.IW(SQW)) u_sqrt_old (
		.clk  (clk),
		.en   (en),
		.rad  (sqv_s6),
		.root (olds)
	);

	// ---------------- |w_i| * old speed, in two partial products
	// the old speed fits W bits since |v|^2 < 2^(2W)
	logic [SPL+W-1:0] plo_s7 [3];
	logic [HW+W-1:0]  phi_s7 [3];
	logic [RW-1:0]    dv_s7, dv_s8;
	logic [NW-1:0]    dd_s8 [3];
	logic [WW-1:0]    mw [3];

	assign mw[0] = mw_out[WW-1:0];
	assign mw[1] = mw_out[2*WW-1:WW];
	assign mw[2] = mw_out[3*WW-1:2*WW];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				plo_s7[i] <= (SPL+W)'(mw[i][SPL-1:0]) * (SPL+W)'(olds[W-1:0]);
				phi_s7[i] <= (HW+W)'(mw[i][WW-1:SPL]) * (HW+W)'(olds[W-1:0]);
				dd_s8[i]  <= (NW'(phi_s7[i]) << SPL) + NW'(plo_s7[i]);
			end
			dv_s7 <= news;
			dv_s8 <= dv_s7;
		end
	end

	// ---------------- rescale divide: quotient never exceeds the old speed unless the new speed is zero
	logic [W-1:0]  quo [3];
	logic [RW-1:0] dvo [3];

	for (genvar i = 0; i < 3; i++) begin : g_div
		vrks_div #(.NW(NW), .DW(RW), .QW(W)) u_div (
			.clk         (clk),
			.en          (en),
			.dividend    (dd_s8[i]),
			.divisor     (dv_s8),
			.quo         (quo[i]),
			.divisor_out (dvo[i])
		);
	end

	// ---------------- clamp, sign, select
	logic          f_valid, f_inv, f_mclip, zero_speed;
	logic [2:0]    f_sgn, over;
	logic [W-1:0]  f_mir [3], lim [3], mg [3], res [3];
	logic [W-1:0]  out_q [3];
	logic          inv_q, sat_q, valid_q;

	always_comb begin
		{f_valid, f_inv, f_mclip, f_sgn} = side_out[SIDW-1:3*W];
		zero_speed = dvo[0] == '0;
		for (int i = 0; i < 3; i++) begin
			f_mir[i] = side_out[i*W +: W];
			lim[i]   = f_sgn[i] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			over[i]  = quo[i] > lim[i];
			mg[i]    = over[i] ? lim[i] : quo[i];
			if (!f_inv) begin
				res[i] = f_mir[i];
			end else if (zero_speed) begin
				res[i] = '0;
			end else begin
				res[i] = f_sgn[i] ? W'(0) - mg[i] : mg[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= f_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				out_q[i] <= res[i];
			end
			inv_q <= f_inv;
			sat_q <= f_inv ? (|over && !zero_speed) : f_mclip;
		end
	end

	assign res_valid       = valid_q;
	assign out_x           = out_q[0];
	assign out_y           = out_q[1];
	assign out_z           = out_q[2];
	assign inverted_branch = inv_q;
	assign saturated       = sat_q;

endmodule

// ===== rtl/vrks_delay.sv =====
// vrks_delay: fixed-length shift line for side data traveling with the pipeline.
// No package dependency.
`timescale 1ns / 1ps

module vrks_delay #(
	parameter int DW    = 8,
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic [DW-1:0] din,
	output logic [DW-1:0] dout
);

	logic [DW-1:0] dly_s [DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DEPTH; k++) begin
				dly_s[k] <= '0;
			end
		end else if (en) begin
			dly_s[0] <= din;
			for (int k = 1; k < DEPTH; k++) begin
				dly_s[k] <= dly_s[k-1];
			end
		end
	end

	assign dout = dly_s[DEPTH-1];

endmodule

// ===== rtl/vrks_front.sv =====
// vrks_front: dot product with the normal and reflected vector w = v + k*p*n,
// k = -2 for the mirror case, 4 for the inverted-normal case. Uses vrks_pkg.
`timescale 1ns / 1ps

module vrks_front #(
	parameter int W = vrks_pkg::VEL_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [W-1:0]               vel_in [3],
	input  logic signed [vrks_pkg::NORM_W-1:0] norm_in [3],
	output logic                              valid_s4,
	output logic                              inv_s4,
	output logic signed [W-1:0]               vel_s4 [3],
	output logic signed [W+8:0]               w_s4 [3]
);

	import vrks_pkg::*;

	localparam int PW  = W + NORM_W;     // v*n product
	localparam int DW  = W + 4;          // dot product
	localparam int PDW = DW + NORM_W;    // dot*n product
	localparam int SCW = PDW + 2;        // scaled by -2 or 4
	localparam int WW  = W + 9;          // reflected vector

	logic                    valid_s1, valid_s2, valid_s3;
	logic signed [PW-1:0]    prod_s1 [3];
	logic signed [W-1:0]     vel_s1 [3], vel_s2 [3], vel_s3 [3];
	logic signed [NORM_W-1:0] nrm_s1 [3], nrm_s2 [3];
	logic signed [DW-1:0]    dot_s2;
	logic signed [PDW-1:0]   pd_s3 [3];
	logic                    inv_s3;
	logic signed [SCW-1:0]   scaled [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			scaled[i] = inv_s3 ? (SCW'(pd_s3[i]) <<< 2) : -(SCW'(pd_s3[i]) <<< 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s1[i] <= PW'(vel_in[i]) * PW'(norm_in[i]);
				vel_s1[i]  <= vel_in[i];
				nrm_s1[i]  <= norm_in[i];
				vel_s2[i]  <= vel_s1[i];
				nrm_s2[i]  <= nrm_s1[i];
				pd_s3[i]   <= PDW'(dot_s2) * PDW'(nrm_s2[i]);
				vel_s3[i]  <= vel_s2[i];
				vel_s4[i]  <= vel_s3[i];
				w_s4[i]    <= WW'(vel_s3[i]) + WW'(scaled[i] >>> NORM_FRAC);
			end
			// each term is floor(v*n / 2^16)
			dot_s2 <= DW'(prod_s1[0] >>> NORM_FRAC) + DW'(prod_s1[1] >>> NORM_FRAC)
				+ DW'(prod_s1[2] >>> NORM_FRAC);
			inv_s3 <= dot_s2 > 0;
			inv_s4 <= inv_s3;
		end
	end

endmodule

// ===== rtl/vrks_sqrt.sv =====
// vrks_sqrt: pipelined restoring integer square root, one root bit per stage.
// No package dependency.
`timescale 1ns / 1ps

module vrks_sqrt #(
	parameter int IW = 84
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IW-1:0]     rad,
	output logic [IW/2-1:0]   root
);

	localparam int RW = IW / 2;

	logic [IW-1:0] rad_s  [RW];
	logic [RW:0]   rem_s  [RW];
	logic [RW-1:0] root_s [RW];

	for (genvar k = 0; k < RW; k++) begin : g_stage
		logic [IW-1:0] rad_p;
		logic [RW:0]   rem_p;
		logic [RW-1:0] root_p;
		logic [RW+2:0] cur, trial;

		if (k == 0) begin : g_first
			assign rad_p  = rad;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
		end

		assign cur   = {rem_p, rad_p[IW-1 -: 2]};
		assign trial = {1'b0, root_p, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k] <= rad_p << 2;
				if (cur >= trial) begin
					rem_s[k]  <= (RW+1)'(cur - trial);
					root_s[k] <= {root_p[RW-2:0], 1'b1};
				end else begin
					rem_s[k]  <= cur[RW:0];
					root_s[k] <= {root_p[RW-2:0], 1'b0};
				end
			end
		end
	end

	assign root = root_s[RW-1];

endmodule

// ===== rtl/vrks_div.sv =====
// vrks_div: pipelined restoring divider, one quotient bit per stage.
// The dividend's upper part must already be below the divisor. No dependencies.
`timescale 1ns / 1ps

module vrks_div #(
	parameter int NW = 73,
	parameter int DW = 42,
	parameter int QW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic [QW-1:0] quo,
	output logic [DW-1:0] divisor_out
);

	logic [DW-1:0] rem_s [QW];
	logic [QW-1:0] low_s [QW];
	logic [DW-1:0] dv_s  [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] rem_p, dv_p;
		logic [QW-1:0] low_p;
		logic [DW:0]   cur;
		logic          ge;

		if (k == 0) begin : g_first
			assign rem_p = DW'(dividend[NW-1:QW]);
			assign low_p = dividend[QW-1:0];
			assign dv_p  = divisor;
		end else begin : g_next
			assign rem_p = rem_s[k-1];
			assign low_p = low_s[k-1];
			assign dv_p  = dv_s[k-1];
		end

		assign cur = {rem_p, low_p[QW-1]};
		assign ge  = cur >= {1'b0, dv_p};

		// quotient bits shift in as dividend bits shift out
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DW'(cur - {1'b0, dv_p}) : DW'(cur);
				low_s[k] <= {low_p[QW-2:0], ge};
				dv_s[k]  <= dv_p;
			end
		end
	end

	assign quo         = low_s[QW-1];
	assign divisor_out = dv_s[QW-1];

endmodule
